[hdl/ttsf_pkg.sv]
`default_nettype none

package ttsf_pkg;

  // Payload widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SEC_W   = 32;
  localparam int unsigned SEGS_W  = 2;
  localparam int unsigned ROLE_W  = 2;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned WIN_W   = 48;

  localparam int unsigned MAX_SEGMENT_DEF = 1460;

  // Commands
  localparam logic [CMD_W-1:0] CMD_RX_BYTE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SENT      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POLL      = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ACCEPTED  = 2'd3;

  // Protocol phases
  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_COOKIE  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PLEN    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_PARAMS  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CREATED = 3'd4;
  localparam logic [PHASE_W-1:0] PH_STARTED = 3'd5;
  localparam logic [PHASE_W-1:0] PH_RUNNING = 3'd6;
  localparam logic [PHASE_W-1:0] PH_ENDING  = 3'd7;

  // Control codes
  localparam logic [BYTE_W-1:0] CB_NONE    = 8'd0;
  localparam logic [BYTE_W-1:0] CB_START   = 8'd1;
  localparam logic [BYTE_W-1:0] CB_RUNNING = 8'd2;
  localparam logic [BYTE_W-1:0] CB_PARAMS  = 8'd9;
  localparam logic [BYTE_W-1:0] CB_CREATE  = 8'd10;
  localparam logic [BYTE_W-1:0] CB_DONE    = 8'd16;

  // Received byte values of interest
  localparam logic [BYTE_W-1:0] RX_TERMINATE = 8'd12;
  localparam logic [BYTE_W-1:0] RX_END_TEST  = 8'd4;
  localparam logic [BYTE_W-1:0] RX_ZERO      = 8'h00;
  localparam logic [BYTE_W-1:0] LETTER_E     = 8'h65;
  localparam logic [WIN_W-1:0]  REVERS_PACKED = 48'h726576657273;

  // Segment length limits
  localparam logic [CNT_W-1:0] LEN_ONE        = 11'd1;
  localparam logic [CNT_W-1:0] LEN_PLEN       = 11'd4;
  localparam logic [CNT_W-1:0] LEN_PARAMS_MIN = 11'd10;
  localparam logic [CNT_W-1:0] LEN_COOKIE_MIN = 11'd30;
  localparam logic [CNT_W-1:0] KEY_TAIL       = 11'd3;

  // Accept roles
  localparam logic [ROLE_W-1:0] ROLE_NONE    = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_CONTROL = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_DATA    = 2'd2;
  localparam logic [ROLE_W-1:0] ROLE_RESTART = 2'd3;

  localparam logic [SEGS_W-1:0] SEGS_NONE = 2'd0;
  localparam logic [SEGS_W-1:0] SEGS_PAIR = 2'd2;

  localparam logic [SEC_W-1:0] POLL_WAIT = 32'd1;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] rx_byte;
    logic              segment_end;
    logic [SEC_W-1:0]  now_seconds;
  } item_t;

  typedef struct packed {
    logic               control_valid;
    logic [BYTE_W-1:0]  control_byte;
    logic [SEGS_W-1:0]  data_segments;
    logic               close_both;
    logic [ROLE_W-1:0]  accept_role;
    logic [PHASE_W-1:0] protocol_state;
    logic               reverse_mode;
    logic [TOTAL_W-1:0] received_total;
  } result_t;

endpackage

`default_nettype wire

[hdl/ttsf_if.sv]
`default_nettype none

interface ttsf_in_if;
  logic                        valid;
  logic                        ready;
  logic [ttsf_pkg::CMD_W-1:0]  command;
  logic [ttsf_pkg::BYTE_W-1:0] rx_byte;
  logic                        segment_end;
  logic [ttsf_pkg::SEC_W-1:0]  now_seconds;

  modport source (output valid, command, rx_byte, segment_end, now_seconds, input ready);
  modport sink   (input valid, command, rx_byte, segment_end, now_seconds, output ready);
endinterface

interface ttsf_out_if;
  logic                         valid;
  logic                         ready;
  logic                         control_valid;
  logic [ttsf_pkg::BYTE_W-1:0]  control_byte;
  logic [ttsf_pkg::SEGS_W-1:0]  data_segments;
  logic                         close_both;
  logic [ttsf_pkg::ROLE_W-1:0]  accept_role;
  logic [ttsf_pkg::PHASE_W-1:0] protocol_state;
  logic                         reverse_mode;
  logic [ttsf_pkg::TOTAL_W-1:0] received_total;

  modport source (output valid, control_valid, control_byte, data_segments, close_both,
                  accept_role, protocol_state, reverse_mode, received_total,
                  input ready);
  modport sink   (input valid, control_valid, control_byte, data_segments, close_both,
                  accept_role, protocol_state, reverse_mode, received_total,
                  output ready);
endinterface

`default_nettype wire

[hdl/throughput_test_server_fsm.sv]
`default_nettype none

// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   command, rx_byte, segment_end, now_seconds
// out_ch    out  valid/ready   control_valid, control_byte, data_segments, close_both,
//                              accept_role, protocol_state, reverse_mode, received_total
//
// Every accepted item yields exactly one result transfer, in order.
// Throughput is one item per cycle while out_ch is not stalled; each item passes through
// the input register, then the step logic into the result register.
// Reset is synchronous on rst_n low and clears all protocol state to idle.
// A stall on out_ch holds the result register; in_ch keeps accepting until the
// input register is also full, then ready drops until out_ch drains.
module throughput_test_server_fsm #(
  parameter int unsigned MAX_SEGMENT = ttsf_pkg::MAX_SEGMENT_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ttsf_in_if.sink     in_ch,
  ttsf_out_if.source  out_ch
);

  ttsf_pkg::item_t   in_item;
  ttsf_pkg::item_t   item;
  ttsf_pkg::result_t result;
  ttsf_pkg::result_t res_r;
  logic              item_valid;
  logic              take;
  logic              out_valid_r, out_valid_nxt;

  // Pack the input transfer's payload.
  always_comb begin
    in_item.command     = in_ch.command;
    in_item.rx_byte     = in_ch.rx_byte;
    in_item.segment_end = in_ch.segment_end;
    in_item.now_seconds = in_ch.now_seconds;
  end

  // Advance the held item whenever the result register is empty or draining.
  assign take = !out_valid_r || out_ch.ready;

  ttsf_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // State updates only on the cycle the item moves into the result register.
  ttsf_ctrl #(
    .MAX_SEGMENT (MAX_SEGMENT)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (item_valid && take),
    .item   (item),
    .result (result)
  );

  assign out_valid_nxt = take ? item_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register: load on advance, hold while stalled.
  always_ff @(posedge clk) begin
    if (item_valid && take) begin
      res_r <= result;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.control_valid  = res_r.control_valid;
  assign out_ch.control_byte   = res_r.control_byte;
  assign out_ch.data_segments  = res_r.data_segments;
  assign out_ch.close_both     = res_r.close_both;
  assign out_ch.accept_role    = res_r.accept_role;
  assign out_ch.protocol_state = res_r.protocol_state;
  assign out_ch.reverse_mode   = res_r.reverse_mode;
  assign out_ch.received_total = res_r.received_total;

  // Input backpressure only comes from a stalled, full result register.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_valid_r && !out_ch.ready))
    else $error("in_ch stalled without output backpressure");

  // A close request always lands the protocol back in idle.
  a_close_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ch.close_both) |-> (out_ch.protocol_state == ttsf_pkg::PH_IDLE))
    else $error("close_both with non-idle state");

  // A control code is present exactly when control_valid is set.
  a_code_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ch.control_valid == (out_ch.control_byte != ttsf_pkg::CB_NONE)))
    else $error("control_byte disagrees with control_valid");

  // Data segments are only requested while running in reverse mode.
  a_segs_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ch.data_segments != ttsf_pkg::SEGS_NONE) |->
      (out_ch.protocol_state == ttsf_pkg::PH_RUNNING && out_ch.reverse_mode))
    else $error("data segments requested outside reverse running");

  // A forced restart always reports idle.
  a_restart_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ch.accept_role == ttsf_pkg::ROLE_RESTART) |->
      (out_ch.protocol_state == ttsf_pkg::PH_IDLE))
    else $error("restart role with non-idle state");

endmodule

`default_nettype wire

[hdl/ttsf_in_reg.sv]
`default_nettype none

// Input register: capture one item, hold it until the step logic takes it.
module ttsf_in_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire ttsf_pkg::item_t in_item,
  input  wire logic            take,
  output      logic            item_valid,
  output      ttsf_pkg::item_t item
);

  logic            valid_r, valid_nxt;
  ttsf_pkg::item_t item_r;

  assign in_ready   = !valid_r || take;
  assign valid_nxt  = in_ready ? in_valid : valid_r;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

[hdl/ttsf_ctrl.sv]
`default_nettype none

// Protocol state and one-step decision logic.
module ttsf_ctrl #(
  parameter int unsigned MAX_SEGMENT = ttsf_pkg::MAX_SEGMENT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire ttsf_pkg::item_t   item,
  output      ttsf_pkg::result_t result
);

  localparam logic [ttsf_pkg::CNT_W-1:0] MAX_CNT = ttsf_pkg::CNT_W'(MAX_SEGMENT);

  logic [ttsf_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic                         rev_r, rev_nxt;
  logic [ttsf_pkg::SEC_W-1:0]   start_r, start_nxt;
  logic [ttsf_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ttsf_pkg::BYTE_W-1:0]  last_r, last_nxt;
  logic [ttsf_pkg::WIN_W-1:0]   win_r, win_nxt;
  logic [ttsf_pkg::CNT_W-1:0]   fme_r, fme_nxt;
  logic                         seen_r, seen_nxt;
  logic [ttsf_pkg::TOTAL_W-1:0] total_r, total_nxt;

  logic                         cvalid, close;
  logic [ttsf_pkg::BYTE_W-1:0]  cbyte;
  logic [ttsf_pkg::SEGS_W-1:0]  segs;
  logic [ttsf_pkg::ROLE_W-1:0]  role;
  logic [ttsf_pkg::SEC_W-1:0]   elapsed;

  assign elapsed = item.now_seconds - start_r;

  always_comb begin
    phase_nxt = phase_r;
    rev_nxt   = rev_r;
    start_nxt = start_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    win_nxt   = win_r;
    fme_nxt   = fme_r;
    seen_nxt  = seen_r;
    total_nxt = total_r;
    cvalid    = 1'b0;
    cbyte     = ttsf_pkg::CB_NONE;
    segs      = ttsf_pkg::SEGS_NONE;
    close     = 1'b0;
    role      = ttsf_pkg::ROLE_NONE;

    unique case (item.command)
      ttsf_pkg::CMD_RX_BYTE: begin
        total_nxt = total_r + 1'b1;
        // Examine only the first MAX_SEGMENT bytes of a segment.
        if (cnt_r < MAX_CNT) begin
          if (!seen_r && win_r == ttsf_pkg::REVERS_PACKED &&
              item.rx_byte == ttsf_pkg::LETTER_E) begin
            seen_nxt = 1'b1;
            fme_nxt  = cnt_r;
          end
          win_nxt  = {win_r[ttsf_pkg::WIN_W-ttsf_pkg::BYTE_W-1:0], item.rx_byte};
          last_nxt = item.rx_byte;
          cnt_nxt  = cnt_r + 1'b1;
        end
        if (item.segment_end) begin
          priority if (cnt_nxt == ttsf_pkg::LEN_ONE && last_nxt == ttsf_pkg::RX_TERMINATE) begin
            phase_nxt = ttsf_pkg::PH_IDLE;
            close     = 1'b1;
            start_nxt = '0;
          end else if (phase_r == ttsf_pkg::PH_IDLE && last_nxt == ttsf_pkg::RX_ZERO &&
                       cnt_nxt > ttsf_pkg::LEN_COOKIE_MIN) begin
            phase_nxt = ttsf_pkg::PH_COOKIE;
            cvalid    = 1'b1;
            cbyte     = ttsf_pkg::CB_PARAMS;
          end else if (phase_r == ttsf_pkg::PH_COOKIE && cnt_nxt == ttsf_pkg::LEN_PLEN) begin
            phase_nxt = ttsf_pkg::PH_PLEN;
          end else if (phase_r == ttsf_pkg::PH_PLEN && cnt_nxt > ttsf_pkg::LEN_PARAMS_MIN) begin
            rev_nxt   = seen_nxt && (fme_nxt <= cnt_nxt - ttsf_pkg::KEY_TAIL);
            phase_nxt = ttsf_pkg::PH_PARAMS;
            cvalid    = 1'b1;
            cbyte     = ttsf_pkg::CB_CREATE;
          end else if (phase_r == ttsf_pkg::PH_PARAMS && last_nxt == ttsf_pkg::RX_ZERO &&
                       cnt_nxt > ttsf_pkg::LEN_COOKIE_MIN) begin
            start_nxt = item.now_seconds;
            if (rev_r) begin
              phase_nxt = ttsf_pkg::PH_STARTED;
              cvalid    = 1'b1;
              cbyte     = ttsf_pkg::CB_START;
            end else begin
              phase_nxt = ttsf_pkg::PH_CREATED;
            end
          end else if (phase_r == ttsf_pkg::PH_RUNNING && last_nxt == ttsf_pkg::RX_END_TEST &&
                       cnt_nxt == ttsf_pkg::LEN_ONE) begin
            cvalid    = 1'b1;
            cbyte     = ttsf_pkg::CB_DONE;
            start_nxt = '0;
            if (rev_r) begin
              phase_nxt = ttsf_pkg::PH_ENDING;
            end else begin
              phase_nxt = ttsf_pkg::PH_IDLE;
              close     = 1'b1;
            end
          end else begin
          end
          cnt_nxt  = '0;
          win_nxt  = '0;
          fme_nxt  = '0;
          seen_nxt = 1'b0;
        end
      end
      ttsf_pkg::CMD_SENT: begin
        priority if (phase_r == ttsf_pkg::PH_CREATED) begin
          phase_nxt = ttsf_pkg::PH_STARTED;
          cvalid    = 1'b1;
          cbyte     = ttsf_pkg::CB_START;
        end else if (phase_r == ttsf_pkg::PH_STARTED) begin
          phase_nxt = ttsf_pkg::PH_RUNNING;
          cvalid    = 1'b1;
          cbyte     = ttsf_pkg::CB_RUNNING;
          total_nxt = '0;
          start_nxt = item.now_seconds;
        end else if (phase_r == ttsf_pkg::PH_RUNNING && rev_r) begin
          segs = ttsf_pkg::SEGS_PAIR;
        end else if (phase_r == ttsf_pkg::PH_ENDING) begin
          phase_nxt = ttsf_pkg::PH_IDLE;
          close     = 1'b1;
        end else begin
        end
      end
      ttsf_pkg::CMD_POLL: begin
        if (phase_r == ttsf_pkg::PH_CREATED && elapsed > ttsf_pkg::POLL_WAIT) begin
          phase_nxt = ttsf_pkg::PH_STARTED;
          start_nxt = item.now_seconds;
          cvalid    = 1'b1;
          cbyte     = ttsf_pkg::CB_START;
        end
      end
      ttsf_pkg::CMD_ACCEPTED: begin
        priority if (phase_r == ttsf_pkg::PH_IDLE) begin
          role = ttsf_pkg::ROLE_CONTROL;
        end else if (phase_r == ttsf_pkg::PH_PARAMS) begin
          role = ttsf_pkg::ROLE_DATA;
        end else begin
          phase_nxt = ttsf_pkg::PH_IDLE;
          role      = ttsf_pkg::ROLE_RESTART;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.control_valid  = cvalid;
    result.control_byte   = cbyte;
    result.data_segments  = segs;
    result.close_both     = close;
    result.accept_role    = role;
    result.protocol_state = phase_nxt;
    result.reverse_mode   = rev_nxt;
    result.received_total = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ttsf_pkg::PH_IDLE;
      rev_r   <= 1'b0;
      start_r <= '0;
      cnt_r   <= '0;
      last_r  <= '0;
      win_r   <= '0;
      fme_r   <= '0;
      seen_r  <= 1'b0;
      total_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      rev_r   <= rev_nxt;
      start_r <= start_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
      win_r   <= win_nxt;
      fme_r   <= fme_nxt;
      seen_r  <= seen_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

`default_nettype wire
